// ----- hdl/dhcp6s_pkg.sv -----
// ----------------------------------------------------------------------------
// DHCPv6 option scanner package
// Beat, result and scan state types shared by the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcp6s_pkg;

	localparam logic [15:0] HEADER_BYTES = 16'd4;
	localparam logic [15:0] POS_MAX      = 16'hFFFF;
	localparam logic [1:0]  HDR_TYPE_END = 2'd2;
	localparam logic [1:0]  HDR_LAST     = 2'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [15:0] message_length;
		logic        last_byte;
	} beat_t;

	typedef struct packed {
		logic        found;
		logic [15:0] opt_type;
		logic [15:0] option_length;
		logic [15:0] value_offset;
	} result_t;

	typedef struct packed {
		logic [1:0]  header_count;
		logic        skipping;
		logic [15:0] current_type;
		logic [15:0] current_length;
		logic [15:0] bytes_remaining;
		logic [15:0] skip_count;
		logic [15:0] byte_position;
		logic        result_given;
	} scan_state_t;

endpackage

`default_nettype wire

// ----- hdl/dhcp6s_if.sv -----
// ----------------------------------------------------------------------------
// DHCPv6 option scanner channels
// Valid/ready channels for option-area bytes and scan results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhcp6s_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic [15:0] message_length;
	logic        last_byte;

	modport source (output valid, data_byte, first_byte, message_length, last_byte,
		input ready);
	modport sink (input valid, data_byte, first_byte, message_length, last_byte,
		output ready);
endinterface

interface dhcp6s_result_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] opt_type;
	logic [15:0] option_length;
	logic [15:0] value_offset;

	modport source (output valid, found, opt_type, option_length, value_offset,
		input ready);
	modport sink (input valid, found, opt_type, option_length, value_offset,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/dhcp6s_step.sv -----
// ----------------------------------------------------------------------------
// DHCPv6 option scanner step
// Next scan state and result for one option-area byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp6s_step (
	input  var dhcp6s_pkg::scan_state_t state,
	input  var dhcp6s_pkg::beat_t       beat,
	input  var logic [15:0]             target_type,
	output var dhcp6s_pkg::scan_state_t next_state,
	output var logic                    result_valid,
	output var dhcp6s_pkg::result_t     result
);

	dhcp6s_pkg::scan_state_t cur;
	logic [15:0] len_new;
	logic [15:0] br_hdr;

	always_comb begin
		cur = state;
		if (beat.first_byte) begin
			cur = '0;
			cur.bytes_remaining = beat.message_length;
		end
	end

	assign len_new = {cur.current_length[7:0], beat.data_byte};
	assign br_hdr  = cur.bytes_remaining - dhcp6s_pkg::HEADER_BYTES;

	always_comb begin
		next_state   = cur;
		result_valid = 1'b0;
		result       = '0;
		if (!cur.result_given) begin
			if (cur.skipping) begin
				next_state.skip_count = cur.skip_count - 16'd1;
				if (cur.skip_count == 16'd1) begin
					next_state.skipping = 1'b0;
				end
			end else if (cur.header_count != 2'd0 ||
					cur.bytes_remaining >= dhcp6s_pkg::HEADER_BYTES) begin
				if (cur.header_count < dhcp6s_pkg::HDR_TYPE_END) begin
					next_state.current_type = {cur.current_type[7:0], beat.data_byte};
				end else begin
					next_state.current_length = len_new;
				end
				if (cur.header_count == dhcp6s_pkg::HDR_LAST) begin
					next_state.header_count = 2'd0;
					if (br_hdr >= len_new) begin
						if (cur.current_type == target_type) begin
							result_valid = 1'b1;
							result.found = 1'b1;
							result.opt_type = cur.current_type;
							result.option_length = len_new;
							result.value_offset = cur.byte_position + 16'd1;
							next_state.result_given = 1'b1;
							next_state.bytes_remaining = br_hdr;
						end else begin
							next_state.bytes_remaining = br_hdr - len_new;
							if (len_new != 16'd0) begin
								next_state.skipping = 1'b1;
								next_state.skip_count = len_new;
							end
						end
					end else begin
						next_state.bytes_remaining = 16'd0;
					end
				end else begin
					next_state.header_count = cur.header_count + 2'd1;
				end
			end
		end
		if (cur.byte_position != dhcp6s_pkg::POS_MAX) begin
			next_state.byte_position = cur.byte_position + 16'd1;
		end
		if (beat.last_byte) begin
			if (!next_state.result_given) begin
				result_valid = 1'b1;
				result = '0;
			end
			next_state.result_given = 1'b1;
			next_state.bytes_remaining = 16'd0;
			next_state.skipping = 1'b0;
			next_state.skip_count = 16'd0;
			next_state.header_count = 2'd0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dhcpv6_option_scanner.sv -----
// ----------------------------------------------------------------------------
// DHCPv6 option scanner
// Walks the TLV options of a DHCPv6 option area and reports the first
// fitting option of the target type, or not-found on the last byte.
// ----------------------------------------------------------------------------
// One option-area byte is taken per clock as long as results are taken; a
// result held at the output stalls the input. A byte is held in an input
// register, the scan state and any result are updated from it, and the
// result sits in an output register, so a result passes the input register
// and the output register before it is offered. The state update loop sets
// the byte rate. Each message gives at most one result beat, and exactly one if it ends with a last byte.
// target_type may be written only while no message is in flight.
`default_nettype none

module dhcpv6_option_scanner (
	input  var logic         clk,
	input  var logic         arst_n,
	input  var logic         cfg_wr_en,
	input  var logic [15:0]  cfg_wr_data,
	dhcp6s_byte_if.sink      in_ch,
	dhcp6s_result_if.source  out_ch
);

	logic [15:0]             target_q;
	logic                    valid_s1;
	dhcp6s_pkg::beat_t       beat_s1;
	dhcp6s_pkg::scan_state_t state_q;
	dhcp6s_pkg::scan_state_t state_d;
	logic                    step_valid;
	dhcp6s_pkg::result_t     step_res;
	logic                    out_valid_q;
	dhcp6s_pkg::result_t     res_q;
	logic                    out_free;
	logic                    advance;
	logic                    in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 16'd0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && (!step_valid || out_free);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			beat_s1.data_byte      <= in_ch.data_byte;
			beat_s1.first_byte     <= in_ch.first_byte;
			beat_s1.message_length <= in_ch.message_length;
			beat_s1.last_byte      <= in_ch.last_byte;
		end
	end

	dhcp6s_step u_step (
		.state        (state_q),
		.beat         (beat_s1),
		.target_type  (target_q),
		.next_state   (state_d),
		.result_valid (step_valid),
		.result       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_q <= step_res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.found         = res_q.found;
	assign out_ch.opt_type      = res_q.opt_type;
	assign out_ch.option_length = res_q.option_length;
	assign out_ch.value_offset  = res_q.value_offset;

	// hold a stalled byte in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(beat_s1)))
		else $error("input register lost a stalled beat");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.found) |->
		(res_q.opt_type == 16'd0 && res_q.option_length == 16'd0 &&
		res_q.value_offset == 16'd0))
		else $error("not-found result carries nonzero fields");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_valid) |=> state_q.result_given)
		else $error("result given without marking the message done");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// DHCPv6 option scanner testbench
// Feeds option areas byte by byte through the valid/ready channels, mirrors
// the option walk in a local scan model and compares every result beat with
// the oldest one due. A short table of hand-built messages comes first, then
// random well-formed, truncated, overrunning and broken messages under
// several target types, and one message with a long skipped option at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BEATS    = 55;
	localparam int PHASE_MESSAGES = 5;
	localparam int REPORT_LIMIT   = 10;

	localparam dhcp6s_pkg::result_t NONE_FOUND  = '0;
	localparam dhcp6s_pkg::result_t FOUND_EMPTY = '{1'b1, 16'd0, 16'd0, 16'd4};

	typedef struct {
		dhcp6s_pkg::beat_t   b;
		bit                  typed;
		dhcp6s_pkg::result_t res;
	} probe_row_t;

	localparam int DIRECTED_ROWS = 24;

	probe_row_t directed_bytes [DIRECTED_ROWS] = '{
		'{'{8'hFF, 1'b0, 16'hFFFF, 1'b1}, 1'b1, NONE_FOUND},
		'{'{8'h00, 1'b1, 16'h0001, 1'b1}, 1'b1, NONE_FOUND},
		'{'{8'hFF, 1'b1, 16'h0002, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'hFF, 1'b0, 16'h0002, 1'b1}, 1'b1, NONE_FOUND},
		'{'{8'h00, 1'b1, 16'h0004, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h0004, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h0004, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h0004, 1'b1}, 1'b1, FOUND_EMPTY},
		'{'{8'h00, 1'b1, 16'h0006, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h0006, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h0006, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h05, 1'b0, 16'h0006, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'hAA, 1'b0, 16'h0006, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h55, 1'b0, 16'h0006, 1'b1}, 1'b1, NONE_FOUND},
		'{'{8'h00, 1'b1, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h07, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h00, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'h02, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'hAB, 1'b0, 16'h000A, 1'b0}, 1'b0, NONE_FOUND},
		'{'{8'hCD, 1'b0, 16'h000A, 1'b1}, 1'b0, NONE_FOUND}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	dhcp6s_byte_if   bytes_ch ();
	dhcp6s_result_if res_ch ();

	dhcp6s_pkg::scan_state_t scan = '0;
	logic [15:0]             target = 16'd0;
	dhcp6s_pkg::result_t     scan_results_due [$];
	dhcp6s_pkg::beat_t       msg_beats [$];
	logic [7:0]              msg_body [$];
	int                      mismatch_count = 0;
	int                      idle_cycles = 0;
	bit                      calm = 1'b0;
	bit                      hold_req = 1'b0;

	dhcpv6_option_scanner dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (bytes_ch),
		.out_ch      (res_ch)
	);

	always #5 clk = ~clk;

	function automatic bit scan_byte(input dhcp6s_pkg::beat_t b,
		output dhcp6s_pkg::result_t r);
		bit hit;
		hit = 1'b0;
		r = NONE_FOUND;
		if (b.first_byte) begin
			scan = '0;
			scan.bytes_remaining = b.message_length;
		end
		if (!scan.result_given) begin
			if (scan.skipping) begin
				scan.skip_count = scan.skip_count - 16'd1;
				if (scan.skip_count == 16'd0)
					scan.skipping = 1'b0;
			end else if (scan.header_count != 2'd0 ||
					scan.bytes_remaining >= dhcp6s_pkg::HEADER_BYTES) begin
				if (scan.header_count < dhcp6s_pkg::HDR_TYPE_END)
					scan.current_type = {scan.current_type[7:0], b.data_byte};
				else
					scan.current_length = {scan.current_length[7:0], b.data_byte};
				if (scan.header_count == dhcp6s_pkg::HDR_LAST) begin
					scan.header_count = 2'd0;
					scan.bytes_remaining = scan.bytes_remaining -
						dhcp6s_pkg::HEADER_BYTES;
					if (scan.bytes_remaining >= scan.current_length) begin
						if (scan.current_type == target) begin
							r = '{1'b1, scan.current_type, scan.current_length,
								scan.byte_position + 16'd1};
							hit = 1'b1;
							scan.result_given = 1'b1;
						end else begin
							scan.bytes_remaining = scan.bytes_remaining - scan.current_length;
							if (scan.current_length != 16'd0) begin
								scan.skipping = 1'b1;
								scan.skip_count = scan.current_length;
							end
						end
					end else begin
						scan.bytes_remaining = 16'd0;
					end
				end else begin
					scan.header_count = scan.header_count + 2'd1;
				end
			end
		end
		if (scan.byte_position != dhcp6s_pkg::POS_MAX)
			scan.byte_position = scan.byte_position + 16'd1;
		if (b.last_byte) begin
			if (!scan.result_given) begin
				r = NONE_FOUND;
				hit = 1'b1;
			end
			scan.result_given = 1'b1;
			scan.bytes_remaining = 16'd0;
			scan.skipping = 1'b0;
			scan.skip_count = 16'd0;
			scan.header_count = 2'd0;
		end
		return hit;
	endfunction

	function automatic void note_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] seen);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %s: expected %04h, got %04h", what, want, seen);
	endfunction

	task automatic send_beat(input dhcp6s_pkg::beat_t b, input bit typed,
		input dhcp6s_pkg::result_t typed_res);
		int                  gap;
		bit                  hit;
		dhcp6s_pkg::result_t due;
		gap = calm ? 0 : int'($urandom_range(0, 3));
		if (gap != 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_ch.valid          <= 1'b1;
		bytes_ch.data_byte      <= b.data_byte;
		bytes_ch.first_byte     <= b.first_byte;
		bytes_ch.message_length <= b.message_length;
		bytes_ch.last_byte      <= b.last_byte;
		do @(posedge clk); while (!bytes_ch.ready);
		hit = scan_byte(b, due);
		if (typed)
			scan_results_due.push_back(typed_res);
		else if (hit)
			scan_results_due.push_back(due);
	endtask

	task automatic send_message();
		foreach (msg_beats[k])
			send_beat(msg_beats[k], 1'b0, NONE_FOUND);
	endtask

	task automatic drain();
		bytes_ch.valid <= 1'b0;
		while (scan_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [15:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		target = value;
	endtask

	// frame the body as beats; only the first beat carries a meaningful length
	task automatic frame_message(input logic [15:0] declared, input bit with_last);
		dhcp6s_pkg::beat_t b;
		msg_beats.delete();
		foreach (msg_body[k]) begin
			b.data_byte      = msg_body[k];
			b.first_byte     = (k == 0);
			b.message_length = (k == 0) ? declared : 16'($urandom);
			b.last_byte      = with_last && (k == msg_body.size() - 1);
			msg_beats.push_back(b);
		end
	endtask

	task automatic build_message(input bit allow_broken);
		logic [15:0]       otype;
		logic [15:0]       olen;
		logic [15:0]       declared;
		int                n_opt;
		int                shape;
		int                cut;
		bit                overrun;
		dhcp6s_pkg::beat_t b;
		msg_beats.delete();
		msg_body.delete();
		// stray beats outside any message
		if (allow_broken && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				b.data_byte      = 8'($urandom);
				b.first_byte     = 1'b0;
				b.message_length = 16'($urandom);
				b.last_byte      = 1'($urandom_range(0, 1));
				msg_beats.push_back(b);
			end
			return;
		end
		shape = $urandom_range(0, 9);
		if (shape == 3) begin
			olen = 16'($urandom_range(256, 65000));
			msg_body.push_back(target[15:8]);
			msg_body.push_back(target[7:0]);
			msg_body.push_back(olen[15:8]);
			msg_body.push_back(olen[7:0]);
			repeat ($urandom_range(0, 2)) msg_body.push_back(8'($urandom));
			declared = 16'($urandom_range(int'(olen) + 4, 65535));
		end else begin
			n_opt = $urandom_range(0, 4);
			for (int i = 0; i < n_opt; i++) begin
				case ($urandom_range(0, 5))
					0, 1: otype = target;
					2: otype = target ^ 16'h0001;
					3: otype = 16'($urandom_range(0, 1) * 16'hFFFF);
					default: otype = 16'($urandom);
				endcase
				overrun = ($urandom_range(0, 9) == 0);
				if (overrun)
					olen = 16'($urandom_range(50, 65535));
				else if ($urandom_range(0, 7) == 0)
					olen = 16'($urandom_range(6, 40));
				else
					olen = 16'($urandom_range(0, 5));
				msg_body.push_back(otype[15:8]);
				msg_body.push_back(otype[7:0]);
				msg_body.push_back(olen[15:8]);
				msg_body.push_back(olen[7:0]);
				if (overrun) begin
					repeat ($urandom_range(0, 3)) msg_body.push_back(8'($urandom));
					break;
				end
				repeat (olen) msg_body.push_back(8'($urandom));
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) msg_body.push_back(8'($urandom));
			if (msg_body.size() == 0)
				msg_body.push_back(8'($urandom));
			declared = 16'(msg_body.size());
			case (shape)
				0: begin
					cut = $urandom_range(1, msg_body.size());
					msg_body = msg_body[0:cut - 1];
				end
				1: repeat ($urandom_range(1, 6)) msg_body.push_back(8'($urandom));
				2: declared = 16'($urandom_range(int'(declared), 65535));
				default: ;
			endcase
		end
		frame_message(declared, !(allow_broken && shape == 4));
	endtask

	always @(posedge clk) begin
		if ((bytes_ch.valid && bytes_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : result_sink
		int                  gap;
		dhcp6s_pkg::result_t got;
		dhcp6s_pkg::result_t want;
		res_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = calm ? 0 : int'($urandom_range(0, 3));
				if (gap != 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got = '{res_ch.found, res_ch.opt_type, res_ch.option_length,
				res_ch.value_offset};
			if (scan_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result beat: found %0b type %04h len %04h off %04h",
						got.found, got.opt_type, got.option_length, got.value_offset);
			end else begin
				want = scan_results_due.pop_front();
				if (got.found !== want.found)
					note_mismatch("found", 16'(want.found), 16'(got.found));
				if (got.opt_type !== want.opt_type)
					note_mismatch("opt_type", want.opt_type, got.opt_type);
				if (got.option_length !== want.option_length)
					note_mismatch("option_length", want.option_length, got.option_length);
				if (got.value_offset !== want.value_offset)
					note_mismatch("value_offset", want.value_offset, got.value_offset);
			end
		end
	end

	initial begin : byte_source
		logic [15:0]       phase_targets [5];
		int                sent;
		int                messages;
		dhcp6s_pkg::beat_t b;
		cfg_wr_en               <= 1'b0;
		cfg_wr_data             <= 16'd0;
		bytes_ch.valid          <= 1'b0;
		bytes_ch.data_byte      <= 8'd0;
		bytes_ch.first_byte     <= 1'b0;
		bytes_ch.message_length <= 16'd0;
		bytes_ch.last_byte      <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// target type still at its reset value
		foreach (directed_bytes[k])
			send_beat(directed_bytes[k].b, directed_bytes[k].typed, directed_bytes[k].res);

		phase_targets[0] = 16'hFFFF;
		phase_targets[1] = 16'h0000;
		phase_targets[2] = 16'($urandom);
		phase_targets[3] = 16'h0017;
		phase_targets[4] = 16'($urandom);
		foreach (phase_targets[p]) begin
			write_target(phase_targets[p]);
			if (p == 0) begin
				// stall the result side and keep single-beat messages coming
				calm = 1'b1;
				hold_req = 1'b1;
				repeat (8) begin
					b.data_byte      = 8'($urandom);
					b.first_byte     = 1'b1;
					b.message_length = 16'($urandom_range(1, 65535));
					b.last_byte      = 1'b1;
					send_beat(b, 1'b0, NONE_FOUND);
				end
				calm = 1'b0;
			end
			sent = 0;
			messages = 0;
			while (sent < PHASE_BEATS || messages < PHASE_MESSAGES) begin
				calm = ($urandom_range(0, 7) == 0);
				build_message(1'b1);
				if (msg_beats[0].first_byte) begin
					sent += msg_beats.size();
					messages++;
				end
				send_message();
			end
			calm = 1'b0;
			build_message(1'b0);
			send_message();
		end

		// one long skipped option, then a match ahead of bytes past the declared end
		write_target(16'hABCD);
		msg_body.delete();
		msg_body.push_back(8'h12);
		msg_body.push_back(8'h34);
		msg_body.push_back(8'h00);
		msg_body.push_back(8'h20);
		repeat (32) msg_body.push_back(8'($urandom));
		msg_body.push_back(8'hAB);
		msg_body.push_back(8'hCD);
		msg_body.push_back(8'h00);
		msg_body.push_back(8'h00);
		repeat (4) msg_body.push_back(8'($urandom));
		frame_message(16'd40, 1'b1);
		send_message();

		drain();
		if (mismatch_count == 0 && scan_results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
